// ===== sv/aab_pkg.sv =====
// ----------------------------------------------------------------------------
// aab_pkg
// Shared types and constants for the ARGB alpha blend unit.
// ----------------------------------------------------------------------------
package aab_pkg;

    localparam int BYTE_W   = 8;
    localparam int LANES    = 4;
    localparam int PIX_W    = BYTE_W * LANES;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = BYTE_W;
    localparam int PROD_W   = PIX_W + BYTE_W;
    localparam int WEIGHT_W = BYTE_W + 1;
    localparam int SUM_W    = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE  = 8'hFF;
    localparam logic [BYTE_W-1:0] OPACITY_RESET = 8'hFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 9'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_SRC_ALPHA = 2'd0,
        MODE_SCALED    = 2'd1,
        MODE_KEEP_DST  = 2'd2,
        MODE_CONST     = 2'd3
    } blend_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE = 1'b0,
        REG_OPACITY    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic bypass;
        logic keep_alpha;
        logic eor;
    } lane_ctl_t;

endpackage

// ===== sv/argb_alpha_blend_unit.sv =====
// ----------------------------------------------------------------------------
// argb_alpha_blend_unit
// Blends an ARGB8888 over pixel onto a base pixel, one word per clock.
//
// Each byte lane computes (d*(256-a) + s*a) >> 8 with d from base_pixel, s
// from over_pixel and a factor a chosen by blend_mode: 0 takes the over alpha
// and passes an opaque over pixel through unchanged, 1 takes
// (opacity*over_pixel)>>32, 2 takes the over alpha but keeps the base alpha
// byte, 3 takes opacity. The datapath is three register stages: factor
// selection (with the 8x32 opacity multiply), the per-lane weighted sums
// (a 9x8 and an 8x8 multiply per lane), and the output register that shifts
// and applies the bypass and alpha-keep rules. A word passes through the
// stage 1, stage 2 and output registers before out_valid rises, and the pipe
// accepts one word every clock while the output side keeps up; each stage
// refills as soon as the stage after it moves, so a stalled output still
// leaves room for up to two more words.
// Write blend_mode (index 0) and opacity (index 1) only while the pipe is
// empty; reset leaves mode 0 and opacity 255.
// ----------------------------------------------------------------------------
module argb_alpha_blend_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [aab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aab_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input words
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [aab_pkg::PIX_W-1:0]        base_pixel,
    input  logic [aab_pkg::PIX_W-1:0]        over_pixel,
    input  logic                             end_of_run,
    // result words
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [aab_pkg::PIX_W-1:0]        blended_pixel,
    output logic                             end_of_run_out
);

    localparam int BW = aab_pkg::BYTE_W;
    localparam int NL = aab_pkg::LANES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    aab_pkg::blend_mode_t     mode_reg;
    logic [BW-1:0]            opacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= aab_pkg::MODE_SRC_ALPHA;
            opacity_reg <= aab_pkg::OPACITY_RESET;
        end
        else if (cfg_we)
        begin
            case (aab_pkg::cfg_reg_t'(cfg_index))
                aab_pkg::REG_BLEND_MODE:
                    mode_reg <= aab_pkg::blend_mode_t'(cfg_data[aab_pkg::MODE_W-1:0]);
                aab_pkg::REG_OPACITY:
                    opacity_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: each stage loads when it is empty or drains forward
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic en1;
    logic en2;
    logic en3;

    assign en3      = !out_valid_reg || out_ready;
    assign en2      = !s2_valid_reg  || en3;
    assign en1      = !s1_valid_reg  || en2;
    assign in_ready = en1;

    // ------------------------------------------------------------------
    // Stage 1: pick the blend factor
    // ------------------------------------------------------------------
    logic [aab_pkg::PROD_W-1:0] scaled_prod;
    logic [BW-1:0]              factor_next;
    logic                       bypass_next;
    logic                       keep_next;

    logic [aab_pkg::PIX_W-1:0]  s1_base_reg;
    logic [aab_pkg::PIX_W-1:0]  s1_over_reg;
    logic [BW-1:0]              s1_factor_reg;
    aab_pkg::lane_ctl_t         s1_ctl_reg;

    assign scaled_prod = aab_pkg::PROD_W'(opacity_reg) * aab_pkg::PROD_W'(over_pixel);

    always_comb
    begin
        bypass_next = 1'b0;
        keep_next   = 1'b0;
        case (mode_reg)
            aab_pkg::MODE_SRC_ALPHA:
            begin
                factor_next = over_pixel[aab_pkg::PIX_W-1 -: BW];
                bypass_next = (over_pixel[aab_pkg::PIX_W-1 -: BW] == aab_pkg::ALPHA_OPAQUE);
            end
            aab_pkg::MODE_SCALED:
                factor_next = scaled_prod[aab_pkg::PROD_W-1 -: BW];
            aab_pkg::MODE_KEEP_DST:
            begin
                factor_next = over_pixel[aab_pkg::PIX_W-1 -: BW];
                keep_next   = 1'b1;
            end
            aab_pkg::MODE_CONST:
                factor_next = opacity_reg;
            default:
                factor_next = opacity_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_base_reg           <= base_pixel;
            s1_over_reg           <= over_pixel;
            s1_factor_reg         <= factor_next;
            s1_ctl_reg.bypass     <= bypass_next;
            s1_ctl_reg.keep_alpha <= keep_next;
            s1_ctl_reg.eor        <= end_of_run;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted sum per byte lane
    // ------------------------------------------------------------------
    logic [aab_pkg::WEIGHT_W-1:0]  inv_weight;
    logic [NL-1:0][aab_pkg::SUM_W-1:0] sum_next;

    logic [NL-1:0][aab_pkg::SUM_W-1:0] s2_sum_reg;
    logic [aab_pkg::PIX_W-1:0]     s2_over_reg;
    logic [BW-1:0]                 s2_base_alpha_reg;
    aab_pkg::lane_ctl_t            s2_ctl_reg;

    assign inv_weight = aab_pkg::WEIGHT_ONE - aab_pkg::WEIGHT_W'(s1_factor_reg);

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            // sum stays below 65281, so the top bit of the 17-bit form is zero
            sum_next[k] = aab_pkg::SUM_W'(
                (17'(s1_base_reg[k*BW +: BW]) * 17'(inv_weight)) +
                (17'(s1_over_reg[k*BW +: BW]) * 17'(s1_factor_reg)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_sum_reg        <= sum_next;
            s2_over_reg       <= s1_over_reg;
            s2_base_alpha_reg <= s1_base_reg[aab_pkg::PIX_W-1 -: BW];
            s2_ctl_reg        <= s1_ctl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: shift down, apply bypass and alpha keep, hold for output
    // ------------------------------------------------------------------
    logic [aab_pkg::PIX_W-1:0] mixed;
    logic [aab_pkg::PIX_W-1:0] pixel_next;
    logic [aab_pkg::PIX_W-1:0] pixel_reg;
    logic                      eor_reg;

    always_comb
    begin
        for (int k = 0; k < NL; k++)
            mixed[k*BW +: BW] = s2_sum_reg[k][aab_pkg::SUM_W-1 -: BW];

        if (s2_ctl_reg.bypass)
            pixel_next = s2_over_reg;
        else if (s2_ctl_reg.keep_alpha)
            pixel_next = {s2_base_alpha_reg, mixed[aab_pkg::PIX_W-BW-1:0]};
        else
            pixel_next = mixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en3)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            pixel_reg <= pixel_next;
            eor_reg   <= s2_ctl_reg.eor;
        end
    end

    assign out_valid      = out_valid_reg;
    assign blended_pixel  = pixel_reg;
    assign end_of_run_out = eor_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty first stage always takes a word.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("in_ready low with stage 1 empty");

    // A full pipe behind a stalled output takes nothing.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("word accepted into a full stalled pipe");

    // An opaque bypass word leaves exactly as it came in.
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (en3 && s2_valid_reg && s2_ctl_reg.bypass) |=>
            (blended_pixel == $past(s2_over_reg)))
        else $error("opaque bypass word changed");

endmodule

// ===== sim/argb_alpha_blend_unit_tb.sv =====
// ----------------------------------------------------------------------------
// argb_alpha_blend_unit_tb
// Self-checking bench for the ARGB alpha blend unit.
//
// A scoreboard object predicts every blended word from the base and over
// pixels and the current mode and opacity, then compares each result word
// field by field in order. Stimulus starts with a few words per blend mode
// at the extremes (opaque bypass, zero and near-full factors, all-zero and
// all-one pixels). It then runs random phases under different register
// settings. In some phases both handshakes idle at random, and one long
// receiver stall fills the pipe and backs up the input side.
// ----------------------------------------------------------------------------
module argb_alpha_blend_unit_tb;

    localparam int BYTE_W     = aab_pkg::BYTE_W;
    localparam int LANES      = aab_pkg::LANES;
    localparam int PIX_W      = aab_pkg::PIX_W;
    localparam int MODE_W     = aab_pkg::MODE_W;
    localparam int CFG_IDX_W  = aab_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = aab_pkg::CFG_DATA_W;
    localparam int PROD_W     = aab_pkg::PROD_W;
    localparam int WEIGHT_W   = aab_pkg::WEIGHT_W;
    localparam int SUM_W      = aab_pkg::SUM_W;

    localparam int STALL_LIMIT   = 1000;  // cycles with no handshake at all
    localparam int PRESSURE_AT   = 400;   // words sent before the long stall
    localparam int PRESSURE_LEN  = 48;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 140;
    localparam int DRAIN_CYCLES  = 4;     // extra idle after the last owed word

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eor;
    } blend_word_t;

    // Scoreboard: holds its own copy of the registers and the queue of
    // blended words still owed by the block.
    class blend_checker;
        aab_pkg::blend_mode_t mode;
        logic [BYTE_W-1:0]    opacity;
        blend_word_t          pixels_due[$];
        int                   errors;

        function new();
            mode    = aab_pkg::MODE_SRC_ALPHA;
            opacity = aab_pkg::OPACITY_RESET;
            errors  = 0;
        endfunction

        function void set_reg(aab_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == aab_pkg::REG_BLEND_MODE)
                mode = aab_pkg::blend_mode_t'(val[MODE_W-1:0]);
            else
                opacity = val;
        endfunction

        // Per lane: (d*(256-a) + s*a) >> 8.
        function logic [PIX_W-1:0] mix_lanes(logic [PIX_W-1:0] b, logic [PIX_W-1:0] o,
                                             logic [WEIGHT_W-1:0] a);
            logic [PIX_W-1:0] res;
            logic [SUM_W:0]   acc;
            res = '0;
            for (int k = 0; k < LANES; k++)
            begin
                acc = b[BYTE_W*k +: BYTE_W] * (aab_pkg::WEIGHT_ONE - a)
                    + o[BYTE_W*k +: BYTE_W] * a;
                res[BYTE_W*k +: BYTE_W] = acc[SUM_W-1:BYTE_W];
            end
            return res;
        endfunction

        function logic [PIX_W-1:0] blend_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] o);
            logic [PROD_W-1:0] prod;
            logic [PIX_W-1:0]  pix;
            case (mode)
                aab_pkg::MODE_SRC_ALPHA:
                    pix = (o[PIX_W-1 -: BYTE_W] == aab_pkg::ALPHA_OPAQUE) ? o
                        : mix_lanes(b, o, {1'b0, o[PIX_W-1 -: BYTE_W]});
                aab_pkg::MODE_SCALED:
                begin
                    prod = opacity * o;
                    pix  = mix_lanes(b, o, {1'b0, prod[PROD_W-1 -: BYTE_W]});
                end
                aab_pkg::MODE_KEEP_DST:
                begin
                    pix = mix_lanes(b, o, {1'b0, o[PIX_W-1 -: BYTE_W]});
                    pix[PIX_W-1 -: BYTE_W] = b[PIX_W-1 -: BYTE_W];
                end
                default:
                    pix = mix_lanes(b, o, {1'b0, opacity});
            endcase
            return pix;
        endfunction

        function void note_input(logic [PIX_W-1:0] b, logic [PIX_W-1:0] o, logic e);
            blend_word_t w;
            w.pixel = blend_pixel(b, o);
            w.eor   = e;
            pixels_due.push_back(w);
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic e);
            blend_word_t w;
            if (pixels_due.size() == 0)
            begin
                $error("result word %h with no word pending", pix);
                errors++;
                return;
            end
            w = pixels_due.pop_front();
            if (pix !== w.pixel)
            begin
                $error("blended_pixel: expected %h, actual %h", w.pixel, pix);
                errors++;
            end
            if (e !== w.eor)
            begin
                $error("end_of_run_out: expected %b, actual %b", w.eor, e);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      base_pixel;
    logic [PIX_W-1:0]      over_pixel;
    logic                  end_of_run;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      blended_pixel;
    logic                  end_of_run_out;

    blend_checker blend_chk = new();
    bit           idle_on;          // random idling on both sides
    int           words_sent;
    bit           pressure_done = 1'b0;
    int           stall_cycles = 0;

    argb_alpha_blend_unit u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_pixel     (base_pixel),
        .over_pixel     (over_pixel),
        .end_of_run     (end_of_run),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .blended_pixel  (blended_pixel),
        .end_of_run_out (end_of_run_out)
    );

    always #5 clk = ~clk;

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one word, hold it until accepted, then idle for a random gap.
    // Valid stays high straight into the next word when the gap is zero;
    // the caller drops it when the stream pauses.
    task automatic push_word(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] o,
                             input logic e);
        int gap;
        in_valid   <= 1'b1;
        base_pixel <= b;
        over_pixel <= o;
        end_of_run <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blend_chk.note_input(b, o, e);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every owed word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (blend_chk.pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input aab_pkg::cfg_reg_t idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        blend_chk.set_reg(idx, val);
    endtask

    // Write both registers; random upper bits in the mode write must be dropped.
    task automatic apply_setting(input aab_pkg::blend_mode_t m,
                                 input logic [BYTE_W-1:0] op);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = CFG_DATA_W'($urandom);
        mode_word[MODE_W-1:0] = m;
        write_reg(aab_pkg::REG_BLEND_MODE, mode_word);
        write_reg(aab_pkg::REG_OPACITY, op);
        cfg_we <= 1'b0;
    endtask

    // Corner pixels: all-ones over, all-ones base, opaque over, alpha 254
    // over, alpha 1 over, and a checker pattern.
    task automatic directed_words();
        push_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        push_word(32'h1234_5678, 32'hFF89_ABCD, 1'b0);
        push_word(32'hFFFF_FFFF, 32'hFE00_0000, 1'b1);
        push_word(32'h00FF_00FF, 32'h01FF_00FF, 1'b0);
        push_word(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
    endtask

    task automatic random_word();
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] o;
        b = $urandom;
        o = $urandom;
        // bias the over alpha toward the interesting values
        case ($urandom_range(0, 7))
            0: o[PIX_W-1 -: BYTE_W] = aab_pkg::ALPHA_OPAQUE;
            1: o[PIX_W-1 -: BYTE_W] = '0;
            2: o[PIX_W-1 -: BYTE_W] = aab_pkg::ALPHA_OPAQUE - 8'd1;
            3: o = '1;
            4: b = ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: ;
        endcase
        push_word(b, o, $urandom_range(0, 7) == 0);
    endtask

    // Receiver: random stalls, plus one long hold once enough words went in.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!pressure_done && words_sent >= PRESSURE_AT)
            begin
                out_ready <= 1'b0;
                repeat (PRESSURE_LEN) @(posedge clk);
                pressure_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Check every result word taken by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            blend_chk.check_result(blended_pixel, end_of_run_out);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        aab_pkg::blend_mode_t m;
        logic [BYTE_W-1:0]    op;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= aab_pkg::REG_BLEND_MODE;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        base_pixel <= '0;
        over_pixel <= '0;
        end_of_run <= 1'b0;
        idle_on       = 1'b0;
        words_sent    = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: reset defaults first, then the other modes.
        directed_words();
        drain();
        apply_setting(aab_pkg::MODE_SCALED, 8'hFF);
        directed_words();
        drain();
        apply_setting(aab_pkg::MODE_KEEP_DST, 8'hFF);
        directed_words();
        drain();
        apply_setting(aab_pkg::MODE_CONST, 8'h00);
        directed_words();
        drain();

        // Random phases: fixed extremes first, then random settings.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin m = aab_pkg::MODE_SRC_ALPHA; op = 8'h00; end
                1: begin m = aab_pkg::MODE_SCALED;    op = 8'hFF; end
                2: begin m = aab_pkg::MODE_SCALED;    op = 8'h00; end
                3: begin m = aab_pkg::MODE_KEEP_DST;  op = 8'h01; end
                4: begin m = aab_pkg::MODE_CONST;     op = 8'hFF; end
                5: begin m = aab_pkg::MODE_CONST;     op = 8'h00; end
                default:
                begin
                    m  = aab_pkg::blend_mode_t'($urandom_range(0, 3));
                    op = BYTE_W'($urandom);
                end
            endcase
            apply_setting(m, op);
            // leave some phases free of idling on both sides
            idle_on = (ph % 3) != 0;
            repeat (PHASE_WORDS) random_word();
            drain();
        end

        if (blend_chk.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
